FILE: hw/rtl/dss_pkg.sv
// dss_pkg: shared constants and types for the drum step sequencer
// used by every module of the block and by its checker; no dependencies

package dss_pkg;

   // default geometry of the sequencer
   localparam int NUM_TRACKS_DEF = 8;
   localparam int SEQ_STEPS_DEF  = 64;
   localparam int PAGE_STEPS_DEF = 16;

   // tempo and timing
   localparam int TEMPO_W     = 10;
   localparam int DIVIDEND_W  = 16;
   localparam int ELAPSED_W   = 17;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

   localparam logic [TEMPO_W-1:0]    START_TEMPO   = 10'd120;
   localparam logic [DIVIDEND_W-1:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX   = 17'd131071;

   // port field widths
   localparam int MODE_W     = 3;
   localparam int SIP_W      = 4;
   localparam int MASK_OUT_W = 8;
   localparam int STEP_OUT_W = 6;
   localparam int TRK_OUT_W  = 3;

   // configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = TEMPO_W;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_FLOOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_CEIL  = 1'd1;

   localparam logic [TEMPO_W-1:0] TEMPO_FLOOR_RST = 10'd40;
   localparam logic [TEMPO_W-1:0] TEMPO_CEIL_RST  = 10'd300;

   // event codes of one item
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK       = 3'd0,
      MODE_TOGGLE     = 3'd1,
      MODE_TEMPO_UP   = 3'd2,
      MODE_TEMPO_DOWN = 3'd3,
      MODE_TRACK_UP   = 3'd4,
      MODE_TRACK_DOWN = 3'd5,
      MODE_PLAY       = 3'd6
   } mode_type;

endpackage

FILE: hw/rtl/dss_divider.sv
// dss_divider: restoring divider, one quotient bit per cycle
// computes milliseconds per minute divided by the tempo; uses dss_pkg

module dss_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dss_pkg::TEMPO_W-1:0]      divisor,
   output logic                             done,
   output logic [dss_pkg::DIVIDEND_W-1:0]   quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [dss_pkg::DIV_CNT_W-1:0]    count_ff, count_in;
   logic [dss_pkg::TEMPO_W-1:0]      rem_ff, rem_in;
   logic [dss_pkg::DIVIDEND_W-1:0]   quo_ff, quo_in;

   logic [dss_pkg::TEMPO_W:0]        shifted;
   logic [dss_pkg::TEMPO_W:0]        diff;
   logic                             fits;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[dss_pkg::DIVIDEND_W-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = dss_pkg::DIV_CNT_W'(dss_pkg::DIVIDEND_W - 1);
         rem_in   = '0;
         quo_in   = dss_pkg::MS_PER_MINUTE;
      end else if (busy_ff) begin
         rem_in = fits ? diff[dss_pkg::TEMPO_W-1:0] : shifted[dss_pkg::TEMPO_W-1:0];
         quo_in = {quo_ff[dss_pkg::DIVIDEND_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/dss_pattern_mem.sv
// dss_pattern_mem: pattern store, one row of track bits per step
// one write and one registered read port, per-row valid bits clear at reset

module dss_pattern_mem #(
   parameter int DEPTH = dss_pkg::SEQ_STEPS_DEF,
   parameter int WIDTH = dss_pkg::NUM_TRACKS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] mem_q_ff;
   logic             vld_q_ff;

   // row valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_q_ff <= valid_ff[rd_addr];
      end
   end

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // a row never written reads as empty
   assign rd_data = vld_q_ff ? mem_q_ff : '0;

endmodule

FILE: hw/rtl/drum_step_sequencer.sv
// drum_step_sequencer: top level, event sequencer around a divider
// depends on dss_pkg, dss_divider and dss_pattern_mem
//
// Takes one event item at a time and returns exactly one result item for it.
// A tick while playing runs the step period (60000 / tempo) through a
// one-bit-per-cycle divider and, when the step advances, reads the new
// step's row before the result; a stopped tick and the tempo, track, play
// and unused events go from decode straight to the result, an in-range
// step toggle through a write of the pattern store first. The next item is
// accepted in the cycle after the result is registered at the earliest.
// The divider's iterations set the tick latency. req_stall stays high from
// acceptance until the result is moved into the output register; a result
// waiting on rsp_stall does not block the next item from being accepted,
// only its result from being registered. The pattern store is clear right
// after reset, with no clearing pass.

module drum_step_sequencer #(
   parameter int NUM_TRACKS = dss_pkg::NUM_TRACKS_DEF,
   parameter int SEQ_STEPS  = dss_pkg::SEQ_STEPS_DEF,
   parameter int PAGE_STEPS = dss_pkg::PAGE_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [dss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // event items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dss_pkg::MODE_W-1:0]        req_mode,
   input  logic [dss_pkg::SIP_W-1:0]         req_step_in_page,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_fired,
   output logic [dss_pkg::MASK_OUT_W-1:0]    rsp_trigger_mask,
   output logic [dss_pkg::STEP_OUT_W-1:0]    rsp_step_now,
   output logic [dss_pkg::TEMPO_W-1:0]       rsp_tempo_now,
   output logic [dss_pkg::TRK_OUT_W-1:0]     rsp_track_now,
   output logic                              rsp_playing_now
);

   localparam int POS_W = $clog2(SEQ_STEPS);
   localparam int IDX_W = POS_W + 1;
   localparam int OFF_W = $clog2(PAGE_STEPS);
   localparam int TRK_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
   localparam int TW    = dss_pkg::TEMPO_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_FETCH,
      S_TOGGLE,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;

   // event latch
   dss_pkg::mode_type           mode_ff, mode_in;
   logic [dss_pkg::SIP_W-1:0]   sip_ff, sip_in;
   logic [POS_W-1:0]            idx_ff, idx_in;

   // sequencer state
   logic [TW-1:0]                     tempo_floor_ff, tempo_floor_in;
   logic [TW-1:0]                     tempo_ceil_ff, tempo_ceil_in;
   logic [TW-1:0]                     tempo_ff, tempo_in;
   logic [POS_W-1:0]                  pos_ff, pos_in;
   logic [POS_W-1:0]                  base_ff, base_in;
   logic [OFF_W-1:0]                  off_ff, off_in;
   logic [TRK_W-1:0]                  trk_ff, trk_in;
   logic                              run_ff, run_in;
   logic [dss_pkg::ELAPSED_W-1:0]     elapsed_ff, elapsed_in;
   logic                              fired_ff, fired_in;
   logic [NUM_TRACKS-1:0]             mask_ff, mask_in;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_fired_ff, rsp_fired_in;
   logic [dss_pkg::MASK_OUT_W-1:0]       rsp_mask_ff, rsp_mask_in;
   logic [dss_pkg::STEP_OUT_W-1:0]       rsp_step_ff, rsp_step_in;
   logic [TW-1:0]                        rsp_tempo_ff, rsp_tempo_in;
   logic [dss_pkg::TRK_OUT_W-1:0]        rsp_trk_ff, rsp_trk_in;
   logic                                 rsp_play_ff, rsp_play_in;

   // divider and pattern store hookup
   logic                             div_start;
   logic                             div_done;
   logic [dss_pkg::DIVIDEND_W-1:0]   div_quotient;
   logic [TW-1:0]                    div_divisor;
   logic [POS_W-1:0]                 mem_rd_addr;
   logic [NUM_TRACKS-1:0]            mem_rd_data;
   logic                             mem_wr_en;
   logic [POS_W-1:0]                 mem_wr_addr;
   logic [NUM_TRACKS-1:0]            mem_wr_data;

   // helpers
   logic [POS_W-1:0]      pos_next;
   logic [IDX_W-1:0]      toggle_idx;
   logic [TW:0]           tempo_up;
   logic [TW-1:0]         tempo_down;
   logic [NUM_TRACKS-1:0] trk_bit;
   logic [15:0]           mask_wide;
   logic [7:0]            pos_wide;
   logic [3:0]            trk_wide;

   dss_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   dss_pattern_mem #(
      .DEPTH (SEQ_STEPS),
      .WIDTH (NUM_TRACKS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // small helpers used by the sequencer
   always_comb begin
      pos_next    = (pos_ff == POS_W'(SEQ_STEPS - 1)) ? '0 : pos_ff + 1'b1;
      toggle_idx  = {1'b0, base_ff} + IDX_W'(sip_ff);
      tempo_up    = {1'b0, tempo_ff} + 1'b1;
      tempo_down  = (tempo_ff == '0) ? '0 : tempo_ff - 1'b1;
      div_divisor = (tempo_ff == '0) ? TW'(1) : tempo_ff;
      for (int i = 0; i < NUM_TRACKS; i++) begin
         trk_bit[i] = (trk_ff == TRK_W'(i));
      end
      mask_wide = 16'(mask_ff);
      pos_wide  = 8'(pos_ff);
      trk_wide  = 4'(trk_ff);
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      sip_in         = sip_ff;
      idx_in         = idx_ff;
      tempo_floor_in = tempo_floor_ff;
      tempo_ceil_in  = tempo_ceil_ff;
      tempo_in       = tempo_ff;
      pos_in         = pos_ff;
      base_in        = base_ff;
      off_in         = off_ff;
      trk_in         = trk_ff;
      run_in         = run_ff;
      elapsed_in     = elapsed_ff;
      fired_in       = fired_ff;
      mask_in        = mask_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_step_in    = rsp_step_ff;
      rsp_tempo_in   = rsp_tempo_ff;
      rsp_trk_in     = rsp_trk_ff;
      rsp_play_in    = rsp_play_ff;
      div_start      = 1'b0;
      mem_rd_addr    = pos_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = idx_ff;
      mem_wr_data    = mem_rd_data ^ trk_bit;

      // configuration writes
      if (csr_wr_en) begin
         unique case (csr_index)
            dss_pkg::CSR_TEMPO_FLOOR: tempo_floor_in = csr_wdata;
            dss_pkg::CSR_TEMPO_CEIL:  tempo_ceil_in  = csr_wdata;
            default: ;
         endcase
      end

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = dss_pkg::mode_type'(req_mode);
               sip_in   = req_step_in_page;
               fired_in = 1'b0;
               mask_in  = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESULT;
            unique case (mode_ff)
               dss_pkg::MODE_TICK: begin
                  if (elapsed_ff != dss_pkg::ELAPSED_MAX) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
                  if (run_ff) begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               dss_pkg::MODE_TOGGLE: begin
                  idx_in      = toggle_idx[POS_W-1:0];
                  mem_rd_addr = toggle_idx[POS_W-1:0];
                  if ((32'(sip_ff) < PAGE_STEPS) && (32'(toggle_idx) < SEQ_STEPS)) begin
                     state_in = S_TOGGLE;
                  end
               end
               dss_pkg::MODE_TEMPO_UP: begin
                  tempo_in = (tempo_up < {1'b0, tempo_ceil_ff}) ? tempo_up[TW-1:0]
                                                                : tempo_ceil_ff;
               end
               dss_pkg::MODE_TEMPO_DOWN: begin
                  tempo_in = (tempo_down > tempo_floor_ff) ? tempo_down : tempo_floor_ff;
               end
               dss_pkg::MODE_TRACK_UP: begin
                  trk_in = (trk_ff == TRK_W'(NUM_TRACKS - 1)) ? '0 : trk_ff + 1'b1;
               end
               dss_pkg::MODE_TRACK_DOWN: begin
                  trk_in = (trk_ff == '0) ? TRK_W'(NUM_TRACKS - 1) : trk_ff - 1'b1;
               end
               dss_pkg::MODE_PLAY: begin
                  run_in = ~run_ff;
               end
               default: ;
            endcase
         end
         S_DIV: begin
            // advance once the step period has gone by
            if (div_done) begin
               if (elapsed_ff >= {1'b0, div_quotient}) begin
                  elapsed_in  = '0;
                  pos_in      = pos_next;
                  mem_rd_addr = pos_next;
                  fired_in    = 1'b1;
                  if (pos_next == '0) begin
                     base_in = '0;
                     off_in  = '0;
                  end else if (off_ff == OFF_W'(PAGE_STEPS - 1)) begin
                     base_in = base_ff + POS_W'(PAGE_STEPS);
                     off_in  = '0;
                  end else begin
                     off_in = off_ff + 1'b1;
                  end
                  state_in = S_FETCH;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_FETCH: begin
            mask_in  = mem_rd_data;
            state_in = S_RESULT;
         end
         S_TOGGLE: begin
            mem_wr_en = 1'b1;
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = fired_ff;
               rsp_mask_in  = mask_wide[dss_pkg::MASK_OUT_W-1:0];
               rsp_step_in  = pos_wide[dss_pkg::STEP_OUT_W-1:0];
               rsp_tempo_in = tempo_ff;
               rsp_trk_in   = trk_wide[dss_pkg::TRK_OUT_W-1:0];
               rsp_play_in  = run_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         tempo_floor_ff <= dss_pkg::TEMPO_FLOOR_RST;
         tempo_ceil_ff  <= dss_pkg::TEMPO_CEIL_RST;
         tempo_ff       <= dss_pkg::START_TEMPO;
         pos_ff         <= '0;
         base_ff        <= '0;
         off_ff         <= '0;
         trk_ff         <= '0;
         run_ff         <= 1'b0;
         elapsed_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tempo_floor_ff <= tempo_floor_in;
         tempo_ceil_ff  <= tempo_ceil_in;
         tempo_ff       <= tempo_in;
         pos_ff         <= pos_in;
         base_ff        <= base_in;
         off_ff         <= off_in;
         trk_ff         <= trk_in;
         run_ff         <= run_in;
         elapsed_ff     <= elapsed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      sip_ff       <= sip_in;
      idx_ff       <= idx_in;
      fired_ff     <= fired_in;
      mask_ff      <= mask_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_tempo_ff <= rsp_tempo_in;
      rsp_trk_ff   <= rsp_trk_in;
      rsp_play_ff  <= rsp_play_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_trigger_mask = rsp_mask_ff;
   assign rsp_step_now     = rsp_step_ff;
   assign rsp_tempo_now    = rsp_tempo_ff;
   assign rsp_track_now    = rsp_trk_ff;
   assign rsp_playing_now  = rsp_play_ff;

endmodule

FILE: hw/rtl/dss_checker.sv
// dss_port_checks: port-level assertions for the drum step sequencer
// bound to drum_step_sequencer; uses dss_pkg for field widths

module dss_port_checks (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_fired,
   input logic [dss_pkg::MASK_OUT_W-1:0]    rsp_trigger_mask,
   input logic [dss_pkg::STEP_OUT_W-1:0]    rsp_step_now,
   input logic                              rsp_playing_now
);

   // a result that did not advance carries no triggers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_trigger_mask == '0)
      else $error("trigger mask set on a result that did not fire");

   // only a running sequencer advances
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_playing_now)
      else $error("step fired while stopped");

   // one item at a time: an accepted item blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous one still in work");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_step_now))
      else $error("stalled result changed");

endmodule

bind drum_step_sequencer dss_port_checks u_dss_port_checks (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_fired        (rsp_fired),
   .rsp_trigger_mask (rsp_trigger_mask),
   .rsp_step_now     (rsp_step_now),
   .rsp_playing_now  (rsp_playing_now)
);
